@@ design/ppt_pkg.sv @@
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared constants and the command and status types of the trace classifier.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 16;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd0;
    localparam logic [2:0] VERDICT_NOT_SURE   = 3'd1;
    localparam logic [2:0] VERDICT_QUEUE      = 3'd2;
    localparam logic [2:0] VERDICT_STACK      = 3'd3;
    localparam logic [2:0] VERDICT_PRIO       = 3'd4;

    // Heap memory operations issued by the controller.
    typedef enum logic [2:0] {
        HOP_NONE,
        HOP_READ,
        HOP_WRITE_V,
        HOP_WRITE_Q,
        HOP_WRITE_A
    } hop_t;

    typedef struct packed {
        logic  load;       // capture the input item
        logic  fq_step;    // issue fifo and stack reads, used on fq_apply
        logic  fq_apply;   // update fifo and stack state
        hop_t  hop;        // heap memory operation
        addr_t haddr;      // heap memory address
        logic  cap_a;      // capture heap read data into the a holding reg
        logic  cap_b;      // capture heap read data into the b holding reg
        logic  hcnt_inc;
        logic  hcnt_dec;
        logic  heap_bad;
        logic  ovf_set;
        logic  clear;      // end of trace
    } cmd_t;

    typedef struct packed {
        logic   op;
        logic   last;
        value_t v;         // item value
        value_t a;         // first heap read
        value_t b;         // second heap read
        value_t r;         // heap read data register
        cnt_t   hcount;
    } sts_t;

endpackage

@@ design/ppt_datapath.sv @@
// ----------------------------------------------------------------------------
// ppt_datapath
// Item registers, the fifo and stack stores, the heap store and the flags.
// ----------------------------------------------------------------------------
module ppt_datapath (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_op,
    input  ppt_pkg::value_t in_value,
    input  logic           in_last,
    input  ppt_pkg::cmd_t  cmd,
    output ppt_pkg::sts_t  sts,
    output logic           fifo_ok,
    output logic           lifo_ok,
    output logic           heap_ok,
    output logic           ovf
);

    ppt_pkg::value_t fifo_mem  [ppt_pkg::CAPACITY];
    ppt_pkg::value_t stack_mem [ppt_pkg::CAPACITY];
    ppt_pkg::value_t heap_mem  [ppt_pkg::CAPACITY];

    logic            op_reg, last_reg;
    ppt_pkg::value_t v_reg, a_reg, b_reg, hrd_reg, frd_reg, srd_reg;
    ppt_pkg::addr_t  head_reg;
    ppt_pkg::cnt_t   fcnt_reg, scnt_reg, hcnt_reg;
    logic            fok_reg, lok_reg, hok_reg, ovf_reg;

    logic f_full, s_full, f_match, s_match;
    ppt_pkg::addr_t tail, s_top;

    assign f_full  = fcnt_reg == ppt_pkg::cnt_t'(ppt_pkg::CAPACITY);
    assign s_full  = scnt_reg == ppt_pkg::cnt_t'(ppt_pkg::CAPACITY);
    assign tail    = head_reg + fcnt_reg[ppt_pkg::ADDR_W-1:0];
    assign s_top   = scnt_reg[ppt_pkg::ADDR_W-1:0] - 1'b1;
    assign f_match = (fcnt_reg != '0) && (frd_reg == v_reg);
    assign s_match = (scnt_reg != '0) && (srd_reg == v_reg);

    // Fifo and stack reads are issued on fq_step and used on fq_apply.
    always_ff @(posedge aclk) begin
        if (cmd.fq_step) begin
            frd_reg <= fifo_mem[head_reg];
            srd_reg <= stack_mem[s_top];
        end
        if (cmd.fq_apply && op_reg == ppt_pkg::OP_PUSH) begin
            if (!f_full) fifo_mem[tail] <= v_reg;
            if (!s_full) stack_mem[scnt_reg[ppt_pkg::ADDR_W-1:0]] <= v_reg;
        end
        unique case (cmd.hop)
            ppt_pkg::HOP_READ:    hrd_reg <= heap_mem[cmd.haddr];
            ppt_pkg::HOP_WRITE_V: heap_mem[cmd.haddr] <= v_reg;
            ppt_pkg::HOP_WRITE_Q: heap_mem[cmd.haddr] <= b_reg;
            ppt_pkg::HOP_WRITE_A: heap_mem[cmd.haddr] <= a_reg;
            default: ;
        endcase
        if (cmd.load) begin
            op_reg   <= in_op;
            last_reg <= in_last;
            v_reg    <= in_value;
        end
        if (cmd.cap_a) a_reg <= hrd_reg;
        if (cmd.cap_b) b_reg <= hrd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            head_reg <= '0;
            fcnt_reg <= '0;
            scnt_reg <= '0;
            hcnt_reg <= '0;
            fok_reg  <= 1'b1;
            lok_reg  <= 1'b1;
            hok_reg  <= 1'b1;
            ovf_reg  <= 1'b0;
        end else begin
            if (cmd.fq_apply) begin
                if (op_reg == ppt_pkg::OP_PUSH) begin
                    if (!f_full) fcnt_reg <= fcnt_reg + 1'b1;
                    if (!s_full) scnt_reg <= scnt_reg + 1'b1;
                    if (f_full || s_full) ovf_reg <= 1'b1;
                end else begin
                    if (f_match) begin
                        head_reg <= head_reg + 1'b1;
                        fcnt_reg <= fcnt_reg - 1'b1;
                    end else begin
                        fok_reg <= 1'b0;
                    end
                    if (s_match) scnt_reg <= scnt_reg - 1'b1;
                    else         lok_reg  <= 1'b0;
                end
            end
            if (cmd.hcnt_inc) hcnt_reg <= hcnt_reg + 1'b1;
            if (cmd.hcnt_dec) hcnt_reg <= hcnt_reg - 1'b1;
            if (cmd.heap_bad) hok_reg  <= 1'b0;
            if (cmd.ovf_set)  ovf_reg  <= 1'b1;
        end
    end

    assign sts     = '{op: op_reg, last: last_reg, v: v_reg, a: a_reg, b: b_reg,
                       r: hrd_reg, hcount: hcnt_reg};
    assign fifo_ok = fok_reg;
    assign lifo_ok = lok_reg;
    assign heap_ok = hok_reg;
    assign ovf     = ovf_reg;

endmodule

@@ design/ppt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppt_ctrl
// Sequencer: fifo and stack update, heap sift-up on push, sift-down on pop,
// then the result.
// ----------------------------------------------------------------------------
module ppt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  ppt_pkg::sts_t sts,
    output ppt_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FQ_RD, ST_FQ_AP,
        ST_UP_RD, ST_UP_WT, ST_UP_CMP,
        ST_PT_WT, ST_PT_CMP,
        ST_LAST_RD, ST_LAST_WT,
        ST_K1_RD, ST_K2_RD, ST_K_WT, ST_K_CMP,
        ST_OUT
    } state_t;

    state_t state_reg;
    ppt_pkg::addr_t pos_reg, kid_reg;
    ppt_pkg::cnt_t  n_reg;      // heap size during sift-down
    logic           two_reg;    // right child exists

    ppt_pkg::addr_t up_idx;
    ppt_pkg::cnt_t  kid_c;
    logic [ppt_pkg::ADDR_W:0] kid_w;
    logic           kid_in, kid2_in, k_right;

    assign up_idx  = (pos_reg - 1'b1) >> 1;
    assign kid_w   = {pos_reg, 1'b1};
    assign kid_c   = ppt_pkg::cnt_t'(kid_w);
    assign kid_in  = kid_c < n_reg;
    assign kid2_in = (kid_c + 1'b1) < n_reg;
    assign k_right = two_reg && (sts.r > sts.b);

    always_comb begin
        cmd       = '0;
        cmd.hop   = ppt_pkg::HOP_NONE;
        cmd.haddr = '0;
        cmd.load  = s_valid && s_ready;
        unique case (state_reg)
            ST_IDLE: ;
            ST_FQ_RD: cmd.fq_step = 1'b1;
            ST_FQ_AP: begin
                cmd.fq_apply = 1'b1;
                if (sts.op == ppt_pkg::OP_PUSH) begin
                    if (sts.hcount == ppt_pkg::cnt_t'(ppt_pkg::CAPACITY))
                        cmd.ovf_set = 1'b1;
                    else cmd.hcnt_inc = 1'b1;
                end else begin
                    cmd.hop = ppt_pkg::HOP_READ;
                end
            end
            ST_UP_RD:  begin cmd.hop = ppt_pkg::HOP_READ; cmd.haddr = up_idx; end
            ST_UP_WT:  cmd.cap_b = 1'b1;
            ST_UP_CMP: begin
                cmd.haddr = pos_reg;
                cmd.hop = (pos_reg == '0 || sts.b >= sts.v) ? ppt_pkg::HOP_WRITE_V
                                                            : ppt_pkg::HOP_WRITE_Q;
            end
            ST_PT_WT: cmd.cap_a = 1'b1;
            ST_PT_CMP: begin
                if (sts.hcount == '0 || sts.a != sts.v) cmd.heap_bad = 1'b1;
                else cmd.hcnt_dec = 1'b1;
            end
            ST_LAST_RD: begin
                cmd.hop = ppt_pkg::HOP_READ;
                cmd.haddr = n_reg[ppt_pkg::ADDR_W-1:0];
            end
            ST_LAST_WT: cmd.cap_a = 1'b1;  // a holds the moving value now
            ST_K1_RD: begin
                // Without a left child the moving value settles here.
                if (kid_in) begin
                    cmd.hop   = ppt_pkg::HOP_READ;
                    cmd.haddr = kid_w[ppt_pkg::ADDR_W-1:0];
                end else begin
                    cmd.hop   = ppt_pkg::HOP_WRITE_A;
                    cmd.haddr = pos_reg;
                end
            end
            ST_K2_RD: begin
                cmd.cap_b = 1'b1;
                if (two_reg) begin
                    cmd.hop = ppt_pkg::HOP_READ; cmd.haddr = kid_reg + 1'b1;
                end
            end
            ST_K_WT: cmd.cap_b = k_right;
            ST_K_CMP: begin
                cmd.haddr = pos_reg;
                cmd.hop = (sts.b <= sts.a) ? ppt_pkg::HOP_WRITE_A : ppt_pkg::HOP_WRITE_Q;
            end
            ST_OUT: cmd.clear = m_ready && sts.last;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (s_valid) state_reg <= ST_FQ_RD;
                ST_FQ_RD: state_reg <= ST_FQ_AP;
                ST_FQ_AP: begin
                    pos_reg <= sts.hcount[ppt_pkg::ADDR_W-1:0];
                    if (sts.op == ppt_pkg::OP_PUSH)
                        state_reg <= (sts.hcount == ppt_pkg::cnt_t'(ppt_pkg::CAPACITY))
                                     ? ST_OUT : ST_UP_RD;
                    else state_reg <= ST_PT_WT;
                end
                ST_UP_RD: state_reg <= ST_UP_WT;
                ST_UP_WT: state_reg <= ST_UP_CMP;
                ST_UP_CMP: begin
                    if (pos_reg == '0 || sts.b >= sts.v) state_reg <= ST_OUT;
                    else begin
                        pos_reg   <= up_idx;
                        state_reg <= ST_UP_RD;
                    end
                end
                ST_PT_WT: state_reg <= ST_PT_CMP;
                ST_PT_CMP: begin
                    if (sts.hcount == '0 || sts.a != sts.v) state_reg <= ST_OUT;
                    else begin
                        n_reg   <= sts.hcount - 1'b1;
                        pos_reg <= '0;
                        state_reg <= (sts.hcount == ppt_pkg::cnt_t'(1)) ? ST_OUT
                                                                      : ST_LAST_RD;
                    end
                end
                ST_LAST_RD: state_reg <= ST_LAST_WT;
                ST_LAST_WT: state_reg <= ST_K1_RD;
                ST_K1_RD: begin
                    if (kid_in) begin
                        kid_reg   <= kid_w[ppt_pkg::ADDR_W-1:0];
                        two_reg   <= kid2_in;
                        state_reg <= ST_K2_RD;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_K2_RD: state_reg <= two_reg ? ST_K_WT : ST_K_CMP;
                ST_K_WT: begin
                    if (k_right) kid_reg <= kid_reg + 1'b1;
                    state_reg <= ST_K_CMP;
                end
                ST_K_CMP: begin
                    if (sts.b <= sts.a) state_reg <= ST_OUT;
                    else begin
                        pos_reg   <= kid_reg;
                        state_reg <= ST_K1_RD;
                    end
                end
                ST_OUT: if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = state_reg == ST_OUT;

endmodule

@@ design/push_pop_trace_structure_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// push_pop_trace_structure_classifier_unit
// Classifies a push/pop trace as queue, stack or priority queue, or as impossible or not sure.
// ----------------------------------------------------------------------------
// One request at a time. A push passes the fifo and stack read and update
// states, then walks the heap sift-up (parent read, wait, compare and write)
// until the item settles, or goes straight to the result when the heap is full.
// A pop passes the same states, reads and checks the heap top and ends there
// when the top does not match or the heap empties; otherwise it reads the last
// item and walks the sift-down level by level. A result waits in the output state
// until taken, and no request is accepted meanwhile.
module push_pop_trace_structure_classifier_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[0], value[16:1], zero fill
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // verdict[2:0], fifo[3], lifo[4], heap[5], ovf[6]
);
    ppt_pkg::cmd_t cmd;
    ppt_pkg::sts_t sts;
    logic fok, lok, hok, ovf;
    logic [1:0] n;
    logic [2:0] verdict;

    ppt_ctrl u_ctrl (.aclk, .aresetn, .s_valid(s_tvalid), .s_ready(s_tready),
        .m_valid(m_tvalid), .m_ready(m_tready), .sts, .cmd);
    ppt_datapath u_dp (.aclk, .aresetn, .in_op(s_tdata[0]), .in_value(s_tdata[16:1]),
        .in_last(s_tlast), .cmd, .sts, .fifo_ok(fok), .lifo_ok(lok), .heap_ok(hok),
        .ovf);

    assign n = 2'(fok) + 2'(lok) + 2'(hok);
    always_comb begin
        priority if (n == 2'd0) verdict = ppt_pkg::VERDICT_IMPOSSIBLE;
        else if (n > 2'd1)      verdict = ppt_pkg::VERDICT_NOT_SURE;
        else if (fok)           verdict = ppt_pkg::VERDICT_QUEUE;
        else if (lok)           verdict = ppt_pkg::VERDICT_STACK;
        else                    verdict = ppt_pkg::VERDICT_PRIO;
    end
    assign m_tdata = {1'b0, ovf, hok, lok, fok, verdict};
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives push/pop traces into the trace classifier and checks every verdict
// against a local FIFO, stack and max-heap model kept in the testbench.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic            op;
        ppt_pkg::value_t val;
        logic            last;
    } trace_op_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       fifo_c;
        logic       lifo_c;
        logic       heap_c;
        logic       ovf;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    push_pop_trace_structure_classifier_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow structures of the classifier.
    ppt_pkg::value_t q_mem[$];
    ppt_pkg::value_t stk_mem[$];
    ppt_pkg::value_t heap_mem[$];
    logic      fifo_ok = 1'b1, lifo_ok = 1'b1, heap_ok = 1'b1, ovf_seen = 1'b0;

    trace_op_t pending_ops[$];
    verdict_t  expected_verdicts[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        hold_until_drained = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Largest-first removal using the same sift rules as a binary heap.
    function automatic void heap_push(ppt_pkg::value_t v);
        int p, up;
        p = heap_mem.size();
        heap_mem.push_back(v);
        while (p > 0) begin
            up = (p - 1) / 2;
            if (heap_mem[up] >= v) break;
            heap_mem[p] = heap_mem[up];
            p = up;
        end
        heap_mem[p] = v;
    endfunction

    function automatic void heap_pop_top();
        ppt_pkg::value_t v;
        int p, kid, n;
        v = heap_mem[heap_mem.size() - 1];
        void'(heap_mem.pop_back());
        n = heap_mem.size();
        if (n == 0) return;
        p = 0;
        forever begin
            kid = 2 * p + 1;
            if (kid >= n) break;
            if (kid + 1 < n && heap_mem[kid + 1] > heap_mem[kid]) kid++;
            if (heap_mem[kid] <= v) break;
            heap_mem[p] = heap_mem[kid];
            p = kid;
        end
        heap_mem[p] = v;
    endfunction

    function automatic verdict_t classify(trace_op_t t);
        verdict_t r;
        int n;
        if (t.op == ppt_pkg::OP_POP) begin
            if (q_mem.size() > 0 && q_mem[0] == t.val) void'(q_mem.pop_front());
            else fifo_ok = 1'b0;
            if (stk_mem.size() > 0 && stk_mem[stk_mem.size() - 1] == t.val)
                void'(stk_mem.pop_back());
            else lifo_ok = 1'b0;
            if (heap_mem.size() > 0 && heap_mem[0] == t.val) heap_pop_top();
            else heap_ok = 1'b0;
        end else begin
            if (q_mem.size() < ppt_pkg::CAPACITY) q_mem.push_back(t.val);
            else ovf_seen = 1'b1;
            if (stk_mem.size() < ppt_pkg::CAPACITY) stk_mem.push_back(t.val);
            else ovf_seen = 1'b1;
            if (heap_mem.size() < ppt_pkg::CAPACITY) heap_push(t.val);
            else ovf_seen = 1'b1;
        end
        n = int'(fifo_ok) + int'(lifo_ok) + int'(heap_ok);
        if (n == 0) r.verdict = ppt_pkg::VERDICT_IMPOSSIBLE;
        else if (n > 1) r.verdict = ppt_pkg::VERDICT_NOT_SURE;
        else if (fifo_ok) r.verdict = ppt_pkg::VERDICT_QUEUE;
        else if (lifo_ok) r.verdict = ppt_pkg::VERDICT_STACK;
        else r.verdict = ppt_pkg::VERDICT_PRIO;
        r.fifo_c = fifo_ok;
        r.lifo_c = lifo_ok;
        r.heap_c = heap_ok;
        r.ovf = ovf_seen;
        if (t.last) begin
            q_mem.delete();
            stk_mem.delete();
            heap_mem.delete();
            fifo_ok = 1'b1; lifo_ok = 1'b1; heap_ok = 1'b1; ovf_seen = 1'b0;
        end
        return r;
    endfunction

    // Stimulus helpers keep a mirror of what the chosen structure would hold so that
    // well-formed traces can be built.
    function automatic void add_op(logic op, ppt_pkg::value_t v, logic last);
        trace_op_t t;
        t.op = op; t.val = v; t.last = last;
        pending_ops.push_back(t);
    endfunction

    function automatic ppt_pkg::value_t rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'hFFFF;
        if (r == 1) return 16'h0000;
        if (r < 5) return ppt_pkg::value_t'($urandom_range(0, 7));
        return ppt_pkg::value_t'($urandom);
    endfunction

    // One trace: pushes and pops; kind 0 queue-like, 1 stack-like,
    // 2 heap-like, 3 noise.
    function automatic void add_trace(int kind, int len);
        ppt_pkg::value_t sh[$];
        ppt_pkg::value_t v;
        int i, k, m;
        for (i = 0; i < len; i++) begin
            if (sh.size() == 0 || $urandom_range(0, 1)) begin
                v = rand_value();
                sh.push_back(v);
                add_op(ppt_pkg::OP_PUSH, v, i == len - 1);
            end else begin
                case (kind)
                    0: begin
                        v = sh[0]; sh.delete(0);
                    end
                    1: begin
                        v = sh[sh.size() - 1]; void'(sh.pop_back());
                    end
                    2: begin
                        m = 0;
                        for (k = 1; k < sh.size(); k++) if (sh[k] > sh[m]) m = k;
                        v = sh[m]; sh.delete(m);
                    end
                    default: begin
                        k = $urandom_range(0, sh.size() - 1);
                        v = ($urandom_range(0, 3) == 0) ? rand_value() : sh[k];
                        sh.delete(k);
                    end
                endcase
                add_op(ppt_pkg::OP_POP, v, i == len - 1);
            end
        end
    endfunction

    // Driver.
    always @(posedge aclk) begin
        trace_op_t t;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_verdicts.push_back(classify({s_tdata[0], s_tdata[16:1], s_tlast}));
                void'(pending_ops.pop_front());
                send_gap <= gap_len();
            end
            if (!(s_tvalid && !s_tready)) begin
                if (s_tvalid && s_tready && send_gap == 0 && pending_ops.size() > 0
                    && !hold_until_drained && gap_len() == 0) begin
                    t = pending_ops[0];
                    s_tdata <= {7'd0, t.val, t.op};
                    s_tlast <= t.last;
                    s_tvalid <= 1'b1;
                end else if (s_tvalid && s_tready) begin
                    s_tvalid <= 1'b0;
                end else if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_ops.size() > 0 && !hold_until_drained) begin
                    t = pending_ops[0];
                    s_tdata <= {7'd0, t.val, t.op};
                    s_tlast <= t.last;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Monitor and scoreboard.
    always @(posedge aclk) begin
        verdict_t exp_v, got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.verdict = m_tdata[2:0];
                got.fifo_c  = m_tdata[3];
                got.lifo_c  = m_tdata[4];
                got.heap_c  = m_tdata[5];
                got.ovf     = m_tdata[6];
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    errors++;
                end else begin
                    exp_v = expected_verdicts.pop_front();
                    if (got.verdict !== exp_v.verdict) begin
                        $error("verdict exp %0d got %0d", exp_v.verdict, got.verdict); errors++;
                    end
                    if (got.fifo_c !== exp_v.fifo_c) begin
                        $error("fifo_consistent exp %0d got %0d", exp_v.fifo_c, got.fifo_c);
                        errors++;
                    end
                    if (got.lifo_c !== exp_v.lifo_c) begin
                        $error("lifo_consistent exp %0d got %0d", exp_v.lifo_c, got.lifo_c);
                        errors++;
                    end
                    if (got.heap_c !== exp_v.heap_c) begin
                        $error("maxheap_consistent exp %0d got %0d", exp_v.heap_c, got.heap_c);
                        errors++;
                    end
                    if (got.ovf !== exp_v.ovf) begin
                        $error("overflow exp %0d got %0d", exp_v.ovf, got.ovf); errors++;
                    end
                    if (m_tdata[7] !== 1'b0) begin
                        $error("fill bit exp 0 got %0d", m_tdata[7]); errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (m_tready && m_tvalid) begin
                recv_gap <= gap_len();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int i, k;
        // Directed part: extremes, the impossible, not sure, queue and stack verdicts, empty pops, broken flags.
        add_op(ppt_pkg::OP_POP, 16'h0000, 1'b0);           // pop on empty structures
        add_op(ppt_pkg::OP_PUSH, 16'hFFFF, 1'b1);
        add_op(ppt_pkg::OP_PUSH, 16'h0001, 1'b0);
        add_op(ppt_pkg::OP_PUSH, 16'h0002, 1'b0);
        add_op(ppt_pkg::OP_POP, 16'h0001, 1'b0);           // queue only
        add_op(ppt_pkg::OP_POP, 16'h0002, 1'b1);
        add_op(ppt_pkg::OP_PUSH, 16'h0001, 1'b0);
        add_op(ppt_pkg::OP_PUSH, 16'h0002, 1'b0);
        add_op(ppt_pkg::OP_POP, 16'h0002, 1'b0);           // stack and heap
        add_op(ppt_pkg::OP_PUSH, 16'h0005, 1'b0);
        add_op(ppt_pkg::OP_PUSH, 16'h0003, 1'b0);
        add_op(ppt_pkg::OP_POP, 16'h0003, 1'b0);           // stack only
        add_op(ppt_pkg::OP_POP, 16'h0005, 1'b0);           // matching pop after a flag cleared
        add_op(ppt_pkg::OP_POP, 16'h0001, 1'b1);
        add_op(ppt_pkg::OP_PUSH, 16'h0003, 1'b0);
        add_op(ppt_pkg::OP_PUSH, 16'h0001, 1'b0);
        add_op(ppt_pkg::OP_PUSH, 16'h0002, 1'b0);
        add_op(ppt_pkg::OP_POP, 16'h0003, 1'b0);           // queue and heap
        add_op(ppt_pkg::OP_POP, 16'hAAAA, 1'b1);           // impossible
        add_op(ppt_pkg::OP_PUSH, 16'h5555, 1'b0);
        add_op(ppt_pkg::OP_POP, 16'h5555, 1'b1);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Fill past capacity once to raise the overflow flag.
        for (i = 0; i < ppt_pkg::CAPACITY + 2; i++)
            add_op(ppt_pkg::OP_PUSH, ppt_pkg::value_t'($urandom), 1'b0);
        add_op(ppt_pkg::OP_POP, 16'h0000, 1'b1);

        for (k = 0; k < 40; k++) add_trace($urandom_range(0, 3), $urandom_range(1, 20));

        // Let everything sent so far come back before continuing.
        wait (pending_ops.size() == 0);
        hold_until_drained = 1'b1;
        wait (expected_verdicts.size() == 0 && !s_tvalid);
        hold_until_drained = 1'b0;

        for (k = 0; k < 12; k++) add_trace($urandom_range(0, 3), $urandom_range(1, 40));
        for (i = 0; i < 40; i++)
            add_op(1'($urandom_range(0, 1)), ppt_pkg::value_t'($urandom),
                   $urandom_range(0, 3) == 0);

        wait (pending_ops.size() == 0 && expected_verdicts.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_verdicts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
